@@ design/chi_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// chi_pkg
// Shared widths, operation codes and the item record of the cubic Hermite core.
// ---------------------------------------------------------------------------
package chi_pkg;

	localparam int DW    = 32;            // data word width
	localparam int FB    = 16;            // fraction bits of data words
	localparam int UF    = 28;            // fraction bits of normalized time
	localparam int TW    = 16;            // tolerance register width
	localparam logic [TW-1:0] TOL_RESET = TW'(16);

	localparam int LW    = DW + 1;        // span and time differences
	localparam int NUW   = LW + UF;       // numerator of normalized time
	localparam int UQ_BITS = UF + 3;      // quotient bits of the time divider
	localparam int URW   = LW + 1;        // time divider remainder
	localparam int UDW   = UF + 2;        // clamped magnitude of u
	localparam int UW    = UF + 3;        // signed u
	localparam int U2W   = UF + 4;        // u squared
	localparam int U3W   = UF + 5;        // signed u cubed
	localparam int HW    = UF + 8;        // basis values
	localparam int PW    = HW + DW;       // basis times data word
	localparam int PLO   = 34;            // low split of the slope products
	localparam int QW    = PW;            // partial products with the span
	localparam int LM2W  = 2 * LW;        // span squared
	localparam int AW    = 104;           // weighted sum
	localparam int EW    = AW + FB;       // scaled numerator before rounding
	localparam int NW    = 96;            // final numerator
	localparam int DDW   = LM2W;          // final divisor
	localparam int RRW   = DDW + 1;       // final divider remainder
	localparam int RQ_BITS = DW;          // quotient bits of the final divider
	localparam int ROUND_U = 1 << (UF - 1);

	localparam logic [1:0] OP_VALUE = 2'd0;
	localparam logic [1:0] OP_SLOPE = 2'd1;
	localparam logic [1:0] OP_CURV  = 2'd2;

	localparam logic [UQ_BITS-1:0] U_MAX = UQ_BITS'(1) << (UF + 1);
	localparam logic [DW-1:0] RES_MAX = {1'b0, {(DW-1){1'b1}}};
	localparam logic [DW-1:0] RES_MIN = {1'b1, {(DW-1){1'b0}}};

	localparam int LATENCY = 2 + (UQ_BITS + 1) + 10 + (RQ_BITS + 1) + 1;

	typedef struct packed {
		logic [1:0]             op;
		logic signed [DW-1:0]   x0;
		logic signed [DW-1:0]   v0;
		logic signed [DW-1:0]   x1;
		logic signed [DW-1:0]   v1;
		logic signed [LW-1:0]   span;
		logic [LW-1:0]          span_mag;
		logic [LM2W-1:0]        span_sq;
		logic                   u_neg;
		logic                   deg;
		logic                   outside;
	} item_t;

	function automatic logic [LW-1:0] mag_l(input logic signed [LW-1:0] x);
		return x[LW-1] ? LW'(-x) : LW'(x);
	endfunction

endpackage

`default_nettype wire

@@ design/cubic_hermite_interpolator_core.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// cubic_hermite_interpolator_core
// Cubic Hermite segment evaluation: value, slope or curvature at a query time.
// ---------------------------------------------------------------------------
// A word is taken at each rising edge where start is high and busy is low;
// busy stays low, so a new word may be started in every cycle. The word holds
// the operation, the query time and the segment's end times, positions and
// slopes. Each result word appears on result and its flags for one cycle with
// done high, in the order the words came in.
// The receiver cannot stall; results are never held back.
// The latency is set by two bit-per-stage dividers: 32 stages that form the
// normalized time u, and 33 stages that divide the weighted sum by the span
// or its square, around 10 stages of multiplies, basis sums and rounding.
// The tolerance register is written through cfg_we / cfg_data and should only
// change while no word is in flight; it resets to 16 LSBs.
// Reset clears every stage valid bit and returns the tolerance to 16; words
// in flight are dropped.
// ---------------------------------------------------------------------------
module cubic_hermite_interpolator_core import chi_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [TW-1:0]        cfg_data,
	input  logic                 start,
	output logic                 busy,
	input  logic [1:0]           operation,
	input  logic signed [DW-1:0] query_time,
	input  logic signed [DW-1:0] start_time,
	input  logic signed [DW-1:0] start_position,
	input  logic signed [DW-1:0] start_slope,
	input  logic signed [DW-1:0] end_time,
	input  logic signed [DW-1:0] end_position,
	input  logic signed [DW-1:0] end_slope,
	output logic                 done,
	output logic signed [DW-1:0] result,
	output logic                 degenerate_span,
	output logic                 outside_span,
	output logic                 saturated
);

	logic [TW-1:0] tol_q;
	logic          accept;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_RESET;
		end else if (cfg_we) begin
			tol_q <= cfg_data;
		end
	end

	// stage 1: input capture
	logic                 v_s1;
	logic [1:0]           op_s1;
	logic signed [DW-1:0] qt_s1, st_s1, x0_s1, v0_s1, et_s1, x1_s1, v1_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1 <= operation;
			qt_s1 <= query_time;
			st_s1 <= start_time;
			x0_s1 <= start_position;
			v0_s1 <= start_slope;
			et_s1 <= end_time;
			x1_s1 <= end_position;
			v1_s1 <= end_slope;
		end
	end

	// stage 2: span, offsets, flags, divider numerator
	logic signed [LW-1:0] span_c, dist_c, dqe_c;
	logic [LW-1:0]        span_mag_c, dist_mag_c;
	logic                 eq_qs_c, eq_qe_c;
	item_t                it_c;
	logic [NUW-1:0]       nu_c;

	always_comb begin
		span_c     = LW'(et_s1) - LW'(st_s1);
		dist_c     = LW'(qt_s1) - LW'(st_s1);
		dqe_c      = LW'(qt_s1) - LW'(et_s1);
		span_mag_c = mag_l(span_c);
		dist_mag_c = mag_l(dist_c);
		eq_qs_c    = dist_mag_c <= LW'(tol_q);
		eq_qe_c    = mag_l(dqe_c) <= LW'(tol_q);
		it_c.op       = (op_s1 inside {OP_VALUE, OP_SLOPE}) ? op_s1 : OP_CURV;
		it_c.x0       = x0_s1;
		it_c.v0       = v0_s1;
		it_c.x1       = x1_s1;
		it_c.v1       = v1_s1;
		it_c.span     = span_c;
		it_c.span_mag = span_mag_c;
		it_c.span_sq  = '0;
		it_c.u_neg    = dist_c[LW-1] != span_c[LW-1];
		it_c.deg      = span_mag_c <= LW'(tol_q);
		it_c.outside  = (dist_c[LW-1] && !eq_qs_c) || (!dqe_c[LW-1] && dqe_c != '0 && !eq_qe_c);
		nu_c = (NUW'(dist_mag_c) << UF) + NUW'(span_mag_c >> 1);
	end

	logic           v_s2;
	item_t          it_s2;
	logic [NUW-1:0] nu_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		it_s2 <= it_c;
		nu_s2 <= nu_c;
	end

	// time divider: u magnitude = nu / span_mag, one quotient bit per stage
	logic               ud_v_sk   [0:UQ_BITS];
	item_t              ud_it_sk  [0:UQ_BITS];
	logic [URW-1:0]     ud_rem_sk [0:UQ_BITS];
	logic [UQ_BITS-1:0] ud_lo_sk  [0:UQ_BITS];
	logic [UQ_BITS-1:0] ud_quo_sk [0:UQ_BITS];
	logic               ud_ovf_sk [0:UQ_BITS];
	item_t              it_sq_c;

	always_comb begin
		it_sq_c         = it_s2;
		it_sq_c.span_sq = LM2W'(it_s2.span_mag) * LM2W'(it_s2.span_mag);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ud_v_sk[0] <= 1'b0;
		end else begin
			ud_v_sk[0] <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		ud_it_sk[0]         <= it_sq_c;
		ud_rem_sk[0]        <= URW'(nu_s2[NUW-1:UQ_BITS]);
		ud_lo_sk[0]         <= nu_s2[UQ_BITS-1:0];
		ud_quo_sk[0]        <= '0;
		// quotient would pass the clamp: the clamp replaces the division result
		ud_ovf_sk[0]        <= URW'(nu_s2[NUW-1:UQ_BITS]) >= URW'(it_s2.span_mag);
	end

	for (genvar k = 0; k < UQ_BITS; k++) begin : g_udiv
		localparam int B = UQ_BITS - 1 - k;
		logic [URW-1:0] trial;
		logic           ge;

		always_comb begin
			trial = {ud_rem_sk[k][URW-2:0], ud_lo_sk[k][B]};
			ge    = trial >= URW'(ud_it_sk[k].span_mag);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ud_v_sk[k+1] <= 1'b0;
			end else begin
				ud_v_sk[k+1] <= ud_v_sk[k];
			end
		end

		always_ff @(posedge clk) begin
			ud_it_sk[k+1]  <= ud_it_sk[k];
			ud_rem_sk[k+1] <= ge ? trial - URW'(ud_it_sk[k].span_mag) : trial;
			ud_lo_sk[k+1]  <= ud_lo_sk[k];
			ud_quo_sk[k+1] <= ud_quo_sk[k] | (UQ_BITS'(ge) << B);
			ud_ovf_sk[k+1] <= ud_ovf_sk[k];
		end
	end

	// stage 4: clamp u to [-2, 2] and apply its sign
	logic [UQ_BITS-1:0]   udm_c;
	logic                 v_s4;
	item_t                it_s4;
	logic [UDW-1:0]       ud_s4;
	logic signed [UW-1:0] u_s4;

	always_comb begin
		udm_c = (ud_ovf_sk[UQ_BITS] || ud_quo_sk[UQ_BITS] > U_MAX) ? U_MAX : ud_quo_sk[UQ_BITS];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= ud_v_sk[UQ_BITS];
		end
	end

	always_ff @(posedge clk) begin
		it_s4 <= ud_it_sk[UQ_BITS];
		ud_s4 <= UDW'(udm_c);
		u_s4  <= ud_it_sk[UQ_BITS].u_neg ? -UW'(udm_c) : UW'(udm_c);
	end

	// stage 5: u squared, rounded
	logic signed [2*UW-1:0] sq_c;
	logic                   v_s5;
	item_t                  it_s5;
	logic [UDW-1:0]         ud_s5;
	logic signed [UW-1:0]   u_s5;
	logic [U2W-1:0]         u2_s5;

	assign sq_c = u_s4 * u_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		it_s5 <= it_s4;
		ud_s5 <= ud_s4;
		u_s5  <= u_s4;
		u2_s5 <= U2W'((sq_c + (2*UW)'(ROUND_U)) >> UF);
	end

	// stage 6: u cubed, rounded on the magnitude
	logic [U2W+UDW-1:0]    m3_c;
	logic [U3W-2:0]        m3r_c;
	logic                  v_s6;
	item_t                 it_s6;
	logic signed [UW-1:0]  u_s6;
	logic [U2W-1:0]        u2_s6;
	logic signed [U3W-1:0] u3_s6;

	always_comb begin
		m3_c  = (U2W+UDW)'(u2_s5) * (U2W+UDW)'(ud_s5);
		m3r_c = (U3W-1)'((m3_c + (U2W+UDW)'(ROUND_U)) >> UF);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		it_s6 <= it_s5;
		u_s6  <= u_s5;
		u2_s6 <= u2_s5;
		u3_s6 <= it_s5.u_neg ? U3W'(-{1'b0, m3r_c}) : U3W'({1'b0, m3r_c});
	end

	// stage 7: basis values
	localparam logic signed [HW-1:0] ONE_H = HW'(1 << UF);
	logic signed [HW-1:0] ue_c, u2e_c, u3e_c, h1_c, h2_c, h3_c, h4_c;
	logic                 v_s7;
	item_t                it_s7;
	logic signed [HW-1:0] h1_s7, h2_s7, h3_s7, h4_s7;

	always_comb begin
		ue_c  = HW'(u_s6);
		u2e_c = HW'($signed({1'b0, u2_s6}));
		u3e_c = HW'(u3_s6);
		case (it_s6.op)
			OP_VALUE: begin
				h1_c = 2 * u3e_c - 3 * u2e_c + ONE_H;
				h2_c = u3e_c - 2 * u2e_c + ue_c;
				h3_c = 3 * u2e_c - 2 * u3e_c;
				h4_c = u3e_c - u2e_c;
			end
			OP_SLOPE: begin
				h1_c = 6 * u2e_c - 6 * ue_c;
				h2_c = 3 * u2e_c - 4 * ue_c + ONE_H;
				h3_c = 6 * ue_c - 6 * u2e_c;
				h4_c = 3 * u2e_c - 2 * ue_c;
			end
			default: begin
				h1_c = 12 * ue_c - 6 * ONE_H;
				h2_c = 6 * ue_c - 4 * ONE_H;
				h3_c = 6 * ONE_H - 12 * ue_c;
				h4_c = 6 * ue_c - 2 * ONE_H;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		it_s7 <= it_s6;
		h1_s7 <= h1_c;
		h2_s7 <= h2_c;
		h3_s7 <= h3_c;
		h4_s7 <= h4_c;
	end

	// stage 8: basis times positions and slopes
	logic                 v_s8;
	item_t                it_s8;
	logic signed [PW-1:0] p1_s8, p2_s8, p3_s8, p4_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else begin
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		it_s8 <= it_s7;
		p1_s8 <= PW'(h1_s7) * PW'($signed(it_s7.x0));
		p2_s8 <= PW'(h2_s7) * PW'($signed(it_s7.v0));
		p3_s8 <= PW'(h3_s7) * PW'($signed(it_s7.x1));
		p4_s8 <= PW'(h4_s7) * PW'($signed(it_s7.v1));
	end

	// stage 9: slope terms times span, split in two partial products
	logic signed [QW-1:0] pl2_s9, ph2_s9, pl4_s9, ph4_s9;
	logic signed [PW-1:0] p1_s9, p3_s9;
	logic                 v_s9;
	item_t                it_s9;
	logic signed [QW-1:0] span_e;

	assign span_e = QW'($signed(it_s8.span));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else begin
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		it_s9  <= it_s8;
		p1_s9  <= p1_s8;
		p3_s9  <= p3_s8;
		pl2_s9 <= $signed({{(QW-PLO){1'b0}}, p2_s8[PLO-1:0]}) * span_e;
		ph2_s9 <= QW'($signed(p2_s8[PW-1:PLO])) * span_e;
		pl4_s9 <= $signed({{(QW-PLO){1'b0}}, p4_s8[PLO-1:0]}) * span_e;
		ph4_s9 <= QW'($signed(p4_s8[PW-1:PLO])) * span_e;
	end

	// stage 10: partial sums
	logic                 v_s10;
	item_t                it_s10;
	logic signed [AW-1:0] s13_s10, s24_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s10 <= 1'b0;
		end else begin
			v_s10 <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		it_s10  <= it_s9;
		s13_s10 <= (AW'(p1_s9) + AW'(p3_s9)) <<< FB;
		s24_s10 <= (AW'(ph2_s9) <<< PLO) + AW'(pl2_s9) + (AW'(ph4_s9) <<< PLO) + AW'(pl4_s9);
	end

	// stage 11: weighted sum
	logic                 v_s11;
	item_t                it_s11;
	logic signed [AW-1:0] acc_s11;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s11 <= 1'b0;
		end else begin
			v_s11 <= v_s10;
		end
	end

	always_ff @(posedge clk) begin
		it_s11  <= it_s10;
		acc_s11 <= s13_s10 + s24_s10;
	end

	// stage 12: sign and magnitude; the slope divides by the signed span
	logic          v_s12;
	item_t         it_s12;
	logic          neg_s12;
	logic [AW-1:0] num_s12;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s12 <= 1'b0;
		end else begin
			v_s12 <= v_s11;
		end
	end

	always_ff @(posedge clk) begin
		it_s12  <= it_s11;
		neg_s12 <= acc_s11[AW-1] ^ (it_s11.op == OP_SLOPE && it_s11.span[LW-1]);
		num_s12 <= acc_s11[AW-1] ? AW'(-acc_s11) : AW'(acc_s11);
	end

	// stage 13: power-of-two part of the divisor with half-divisor rounding
	logic [EW-1:0]  t_c;
	logic [NW-1:0]  n_c;
	logic [DDW-1:0] den_c;
	logic           v_s13;
	item_t          it_s13;
	logic           neg_s13;
	logic [NW-1:0]  n_s13;
	logic [DDW-1:0] den_s13;

	always_comb begin
		case (it_s12.op)
			OP_VALUE: begin
				t_c   = (EW'(num_s12) + (EW'(1) << (UF + FB - 1))) >> (UF + FB);
				den_c = DDW'(1);
			end
			OP_SLOPE: begin
				t_c   = (EW'(num_s12) + (EW'(it_s12.span_mag) << (UF - 1))) >> UF;
				den_c = DDW'(it_s12.span_mag);
			end
			default: begin
				t_c   = ((EW'(num_s12) << FB) + (EW'(it_s12.span_sq) << (UF - 1))) >> UF;
				den_c = it_s12.span_sq;
			end
		endcase
		n_c = NW'(t_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s13 <= 1'b0;
		end else begin
			v_s13 <= v_s12;
		end
	end

	always_ff @(posedge clk) begin
		it_s13  <= it_s12;
		neg_s13 <= neg_s12;
		n_s13   <= n_c;
		den_s13 <= den_c;
	end

	// final divider: n / den, one quotient bit per stage
	logic               rq_v_sk   [0:RQ_BITS];
	item_t              rq_it_sk  [0:RQ_BITS];
	logic               rq_neg_sk [0:RQ_BITS];
	logic [DDW-1:0]     rq_den_sk [0:RQ_BITS];
	logic [RRW-1:0]     rq_rem_sk [0:RQ_BITS];
	logic [RQ_BITS-1:0] rq_lo_sk  [0:RQ_BITS];
	logic [RQ_BITS-1:0] rq_quo_sk [0:RQ_BITS];
	logic               rq_ovf_sk [0:RQ_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rq_v_sk[0] <= 1'b0;
		end else begin
			rq_v_sk[0] <= v_s13;
		end
	end

	always_ff @(posedge clk) begin
		rq_it_sk[0]  <= it_s13;
		rq_neg_sk[0] <= neg_s13;
		rq_den_sk[0] <= den_s13;
		rq_rem_sk[0] <= RRW'(n_s13[NW-1:RQ_BITS]);
		rq_lo_sk[0]  <= n_s13[RQ_BITS-1:0];
		rq_quo_sk[0] <= '0;
		// quotient of 2^32 or more saturates unless the span is degenerate
		rq_ovf_sk[0] <= RRW'(n_s13[NW-1:RQ_BITS]) >= RRW'(den_s13);
	end

	for (genvar k = 0; k < RQ_BITS; k++) begin : g_rdiv
		localparam int B = RQ_BITS - 1 - k;
		logic [RRW-1:0] trial;
		logic           ge;

		always_comb begin
			trial = {rq_rem_sk[k][RRW-2:0], rq_lo_sk[k][B]};
			ge    = trial >= RRW'(rq_den_sk[k]);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rq_v_sk[k+1] <= 1'b0;
			end else begin
				rq_v_sk[k+1] <= rq_v_sk[k];
			end
		end

		always_ff @(posedge clk) begin
			rq_it_sk[k+1]  <= rq_it_sk[k];
			rq_neg_sk[k+1] <= rq_neg_sk[k];
			rq_den_sk[k+1] <= rq_den_sk[k];
			rq_rem_sk[k+1] <= ge ? trial - RRW'(rq_den_sk[k]) : trial;
			rq_lo_sk[k+1]  <= rq_lo_sk[k];
			rq_quo_sk[k+1] <= rq_quo_sk[k] | (RQ_BITS'(ge) << B);
			rq_ovf_sk[k+1] <= rq_ovf_sk[k];
		end
	end

	// output: saturation, sign, degenerate span override
	item_t              it_f;
	logic [RQ_BITS-1:0] qv_f;
	logic [DW-1:0]      res_c;
	logic               sat_c;

	always_comb begin
		it_f = rq_it_sk[RQ_BITS];
		qv_f = rq_quo_sk[RQ_BITS];
		if (it_f.deg) begin
			res_c = (it_f.op == OP_VALUE) ? it_f.x0 : it_f.v0;
			sat_c = 1'b0;
		end else if (rq_neg_sk[RQ_BITS]) begin
			sat_c = rq_ovf_sk[RQ_BITS] || (qv_f[RQ_BITS-1] && qv_f[RQ_BITS-2:0] != '0);
			res_c = sat_c ? RES_MIN : DW'(-qv_f);
		end else begin
			sat_c = rq_ovf_sk[RQ_BITS] || qv_f[RQ_BITS-1];
			res_c = sat_c ? RES_MAX : DW'(qv_f);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= rq_v_sk[RQ_BITS];
		end
	end

	always_ff @(posedge clk) begin
		result          <= res_c;
		degenerate_span <= it_f.deg;
		outside_span    <= it_f.outside;
		saturated       <= sat_c;
	end

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LATENCY))
		else $error("result word without a start word at the pipeline depth");

	a_sat_extreme: assert property (@(posedge clk) disable iff (!arst_n)
		done && saturated |-> result == RES_MAX || result == RES_MIN)
		else $error("saturated result is not a range limit");

	a_deg_nosat: assert property (@(posedge clk) disable iff (!arst_n)
		done && degenerate_span |-> !saturated)
		else $error("degenerate span flagged as saturated");

	a_u_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> UQ_BITS'(ud_s4) <= U_MAX)
		else $error("normalized time escaped its clamp");

endmodule

`default_nettype wire
